// File: design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define CHK_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
// Condition that must hold while a word is stalled on a channel.
`define CHK_STALL_HOLD(lbl, clk, rst_n, vld, rdy, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (vld && !rdy) |=> (cond)) \
		else $error("stalled word changed");
`endif

// File: design/ddo_pkg.sv
// Shared types, constants and tables for the odometry block.
package ddo_pkg;
	localparam int CORDIC_STEPS = 16;
	localparam int MUL_W = 34;
	localparam int PROD_W = 2 * MUL_W;
	localparam int Z_W = 28;
	localparam logic [15:0] TWO_PI_Q13 = 16'd51472;
	localparam logic signed [17:0] PI_Q13 = 18'sd25736;
	localparam logic signed [Z_W-1:0] PI_Q24 = 28'sd52707179;
	localparam logic signed [Z_W-1:0] HALF_PI_Q24 = 28'sd26353589;
	localparam logic signed [MUL_W-1:0] GAIN_Q30 = 34'sd652032874;
	// 2^33 mod 2*pi(Q13): correction for the sign weight of the 33-bit mid angle
	localparam logic [15:0] WRAP_K = 16'((64'd1 << 33) % 64'd51472);
	localparam logic [1:0] REG_DPC = 2'd0;
	localparam logic [1:0] REG_IWB = 2'd1;

	typedef struct packed {
		logic signed [31:0] left_count;
		logic signed [31:0] right_count;
		logic signed [15:0] gyro_yaw;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [15:0] heading;
		logic signed [31:0] turn_total;
	} out_word_t;

	typedef struct packed {
		logic                    go;
		logic signed [MUL_W-1:0] a;
		logic signed [MUL_W-1:0] b;
	} mul_req_t;

	function automatic logic signed [Z_W-1:0] atan_q24(input logic [4:0] i);
		logic signed [Z_W-1:0] v;
		case (i)
			5'd0: v = 28'sd13176795;
			5'd1: v = 28'sd7778716;
			5'd2: v = 28'sd4110060;
			5'd3: v = 28'sd2086331;
			5'd4: v = 28'sd1047214;
			5'd5: v = 28'sd524117;
			5'd6: v = 28'sd262123;
			5'd7: v = 28'sd131069;
			default: v = (i < 5'd24) ? (28'sd65536 >>> (i - 5'd8)) : 28'sd0;
		endcase
		return v;
	endfunction
endpackage

// File: design/ddo_mul.sv
// Bit-serial signed multiplier, one multiplier bit per cycle.
module ddo_mul import ddo_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  mul_req_t                 req,
	output logic                     done,
	output logic signed [PROD_W-1:0] prod
);
	logic signed [PROD_W-1:0] acc_q, m_q, addend;
	logic [MUL_W-1:0] b_q;
	logic [5:0] cnt_q;
	logic busy_q, done_q, last;

	assign last = (cnt_q == 6'(MUL_W - 1));
	// sign bit of b carries negative weight
	assign addend = !b_q[0] ? '0 : (last ? -m_q : m_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= busy_q && last;
			if (req.go) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (last) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			acc_q <= '0;
			m_q <= PROD_W'(req.a);
			b_q <= req.b;
		end else if (busy_q) begin
			acc_q <= acc_q + addend;
			m_q <= m_q <<< 1;
			b_q <= b_q >> 1;
		end
	end

	assign done = done_q;
	assign prod = acc_q;
endmodule

// File: design/differential_drive_odometry.sv
// Top level of the differential-drive odometry block.
// Usage:
//  - in channel (in_valid/in_ready/in_data): one word per sample with the
//    absolute left/right encoder counts and the gyro yaw.
//  - out channel (out_valid/out_ready/out_data): one word per input word with
//    the updated x/y position, fused heading and unwrapped heading total.
//  - cfg port (cfg_we/cfg_index/cfg_data): distance per count (index 0) and
//    inverse wheel base (index 1); write only while the block is idle.
// Timing: one word at a time; the next word can be accepted at the earliest in
//  the cycle in which out_valid rises. Five products run through one bit-serial
//  multiplier, the mid angle is reduced mod 2*pi and the CORDIC rotates it;
//  then the output register is loaded. A new word is accepted once the previous
//  result sits in the output register, so a stalled receiver holds at most one
//  result there.
// Reset: positions, heading, totals and previous counts clear to zero and the
//  registers return to their defaults; out_valid drops.
// Stall: out_data holds until out_ready; the sequencer waits for the output
//  register to free before it writes the next result.
module differential_drive_odometry import ddo_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_word_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_word_t   out_data,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data
);
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_ML   = 4'd1;
	localparam logic [3:0] ST_MR   = 4'd2;
	localparam logic [3:0] ST_MP   = 4'd3;
	localparam logic [3:0] ST_MOD  = 4'd4;
	localparam logic [3:0] ST_ROT  = 4'd5;
	localparam logic [3:0] ST_MX   = 4'd6;
	localparam logic [3:0] ST_MY   = 4'd7;
	localparam logic [3:0] ST_OUT  = 4'd8;

	logic [3:0] state_q;
	logic [23:0] dpc_q, iwb_q;
	logic signed [31:0] prev_l_q, prev_r_q, x_acc_q, y_acc_q, total_q;
	logic signed [15:0] heading_q, gyro_q;
	logic signed [31:0] dr_q, wl_q, dd_q, dpsi_q, xp_q;
	logic signed [MUL_W-1:0] sin_q;
	// multiplier request
	logic req_go_q, mul_go;
	logic signed [MUL_W-1:0] req_a_q, req_b_q;
	mul_req_t mul_req;
	logic mul_done;
	logic signed [PROD_W-1:0] prod;
	// mod reduction
	logic [32:0] msh_q;
	logic msign_q;
	logic [15:0] rem_q;
	logic [5:0] mcnt_q;
	// CORDIC
	logic signed [MUL_W-1:0] cx_q, cy_q;
	logic signed [Z_W-1:0] cz_q;
	logic flip_q;
	logic [4:0] it_q;
	out_word_t out_q;
	logic out_valid_q;

	assign mul_req = '{go: req_go_q, a: req_a_q, b: req_b_q};

	ddo_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mul_req), .done(mul_done), .prod(prod));

	logic in_acc;
	assign in_acc = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);

	// wheel travel differences
	logic signed [31:0] dl_in, dr_in, wr_new;
	logic signed [32:0] wdiff, wsum;
	assign dl_in = prev_l_q - in_data.left_count;
	assign dr_in = in_data.right_count - prev_r_q;
	assign wr_new = prod[39:8];
	assign wdiff = 33'(wr_new) - 33'(wl_q);
	assign wsum = 33'(wr_new) + 33'(wl_q);

	// mid angle h + dpsi/2, 33 bits
	logic signed [31:0] dpsi_new;
	logic signed [32:0] mid;
	assign dpsi_new = prod[50:19];
	assign mid = 33'(heading_q) + 33'(dpsi_new >>> 1);

	// one restoring step of the reduction
	logic [16:0] rstep;
	logic [15:0] rnext;
	assign rstep = {rem_q, msh_q[32]};
	assign rnext = (rstep >= 17'(TWO_PI_Q13)) ? 16'(rstep - 17'(TWO_PI_Q13)) : rstep[15:0];

	// sign correction, wrap into (-pi, pi], fold into [-pi/2, pi/2]
	logic signed [17:0] r1, r2, r3;
	logic signed [Z_W-1:0] z0, zf;
	logic fl;
	always_comb begin
		r1 = $signed({2'b00, rnext}) - (msign_q ? $signed({2'b00, WRAP_K}) : 18'sd0);
		r2 = (r1 < 0) ? r1 + $signed({2'b00, TWO_PI_Q13}) : r1;
		r3 = (r2 > PI_Q13) ? r2 - $signed({2'b00, TWO_PI_Q13}) : r2;
		z0 = Z_W'(r3) <<< 11;
		fl = 1'b0;
		zf = z0;
		if (z0 > HALF_PI_Q24) begin
			zf = z0 - PI_Q24;
			fl = 1'b1;
		end else if (z0 < -HALF_PI_Q24) begin
			zf = z0 + PI_Q24;
			fl = 1'b1;
		end
	end

	// CORDIC iteration
	logic signed [MUL_W-1:0] xs, ys, cx_n, cy_n, cos_v, sin_v;
	logic signed [Z_W-1:0] cz_n;
	always_comb begin
		xs = cx_q >>> it_q;
		ys = cy_q >>> it_q;
		if (!cz_q[Z_W-1]) begin
			cx_n = cx_q - ys;
			cy_n = cy_q + xs;
			cz_n = cz_q - atan_q24(it_q);
		end else begin
			cx_n = cx_q + ys;
			cy_n = cy_q - xs;
			cz_n = cz_q + atan_q24(it_q);
		end
		cos_v = flip_q ? -cx_n : cx_n;
		sin_v = flip_q ? -cy_n : cy_n;
	end

	// fused heading
	logic signed [33:0] hsum;
	logic signed [33:0] hs0, hs1, hs2;
	always_comb begin
		hsum = 34'(gyro_q) + 34'(heading_q) + 34'(dpsi_q);
		hs0 = hsum >>> 1;
		hs1 = (hs0 >= 34'(PI_Q13)) ? hs0 - 34'(TWO_PI_Q13) : hs0;
		hs2 = (hs1 <= -34'(PI_Q13)) ? hs1 + 34'(TWO_PI_Q13) : hs1;
	end

	logic out_free;
	assign out_free = !out_valid_q || out_ready;

	// multiplier start: one pulse per product
	always_comb begin
		case (state_q)
			ST_IDLE: mul_go = in_acc;
			ST_ML, ST_MR, ST_MX: mul_go = mul_done;
			ST_ROT: mul_go = (it_q == 5'(CORDIC_STEPS - 1));
			default: mul_go = 1'b0;
		endcase
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dpc_q <= 24'd1024;
			iwb_q <= 24'd327680;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DPC: dpc_q <= cfg_data;
				REG_IWB: iwb_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			req_go_q <= 1'b0;
			out_valid_q <= 1'b0;
			prev_l_q <= '0;
			prev_r_q <= '0;
			x_acc_q <= '0;
			y_acc_q <= '0;
			heading_q <= '0;
			total_q <= '0;
		end else begin
			req_go_q <= mul_go;
			if (state_q == ST_OUT && out_free) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (in_acc) begin
					prev_l_q <= in_data.left_count;
					prev_r_q <= in_data.right_count;
					state_q <= ST_ML;
				end
				ST_ML: if (mul_done) state_q <= ST_MR;
				ST_MR: if (mul_done) state_q <= ST_MP;
				ST_MP: if (mul_done) state_q <= ST_MOD;
				ST_MOD: if (mcnt_q == 6'd32) state_q <= ST_ROT;
				ST_ROT: if (it_q == 5'(CORDIC_STEPS - 1)) state_q <= ST_MX;
				ST_MX: if (mul_done) state_q <= ST_MY;
				ST_MY: if (mul_done) state_q <= ST_OUT;
				ST_OUT: if (out_free) begin
					x_acc_q <= x_acc_q + xp_q;
					y_acc_q <= y_acc_q + prod[61:30];
					heading_q <= hs2[15:0];
					total_q <= total_q + dpsi_q;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (in_acc) begin
				gyro_q <= in_data.gyro_yaw;
				dr_q <= dr_in;
				req_a_q <= MUL_W'(dl_in);
				req_b_q <= MUL_W'({1'b0, dpc_q});
			end
			ST_ML: if (mul_done) begin
				wl_q <= prod[39:8];
				req_a_q <= MUL_W'(dr_q);
				req_b_q <= MUL_W'({1'b0, dpc_q});
			end
			ST_MR: if (mul_done) begin
				dd_q <= wsum[32:1];
				req_a_q <= MUL_W'(wdiff);
				req_b_q <= MUL_W'({1'b0, iwb_q});
			end
			ST_MP: if (mul_done) begin
				dpsi_q <= dpsi_new;
				msh_q <= mid;
				msign_q <= mid[32];
				rem_q <= '0;
				mcnt_q <= '0;
			end
			ST_MOD: begin
				rem_q <= rnext;
				msh_q <= msh_q << 1;
				mcnt_q <= mcnt_q + 6'd1;
				if (mcnt_q == 6'd32) begin
					cz_q <= zf;
					flip_q <= fl;
					cx_q <= GAIN_Q30;
					cy_q <= '0;
					it_q <= '0;
				end
			end
			ST_ROT: begin
				cx_q <= cx_n;
				cy_q <= cy_n;
				cz_q <= cz_n;
				it_q <= it_q + 5'd1;
				if (it_q == 5'(CORDIC_STEPS - 1)) begin
					sin_q <= sin_v;
					req_a_q <= MUL_W'(dd_q);
					req_b_q <= cos_v;
				end
			end
			ST_MX: if (mul_done) begin
				xp_q <= prod[61:30];
				req_b_q <= sin_q;
			end
			ST_OUT: if (out_free) begin
				out_q.pos_x <= x_acc_q + xp_q;
				out_q.pos_y <= y_acc_q + prod[61:30];
				out_q.heading <= hs2[15:0];
				out_q.turn_total <= total_q + dpsi_q;
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;
endmodule

// File: design/ddo_check.sv
// Port-level checks for the odometry block, bound to the top level.
`include "assert_macros.svh"
module ddo_check import ddo_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input out_word_t   out_data
);
	`CHK_STALL_HOLD(a_out_hold, clk, arst_n, out_valid, out_ready, out_valid && $stable(out_data))
	`CHK_ASSERT(a_busy_after_accept, clk, arst_n, (in_valid && in_ready) |=> !in_ready)
	`CHK_ASSERT(a_result_from_busy, clk, arst_n, $rose(out_valid) |-> $past(!in_ready))
	`CHK_ASSERT(a_no_quick_result, clk, arst_n, (in_valid && in_ready) |=> ##1 !$rose(out_valid))
endmodule

bind differential_drive_odometry ddo_check u_ddo_check (.*);
